// ===== rtl/mwcrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcrc_pkg
// Shared types, register codes, preset catalogue and per-width byte folding
// for the multi-width CRC preset engine.
// ----------------------------------------------------------------------------
package mwcrc_pkg;

  // Configuration register indexes
  localparam logic CFG_CRC_WIDTH = 1'b0;
  localparam logic CFG_PRESET    = 1'b1;

  // Width select codes
  localparam logic [1:0] WIDTH_CRC8  = 2'd0;
  localparam logic [1:0] WIDTH_CRC16 = 2'd1;
  localparam logic [1:0] WIDTH_CRC32 = 2'd2;

  // One catalogue entry
  typedef struct packed {
    logic [31:0] poly;
    logic [31:0] init;
    logic [31:0] xorout;
    logic        refl;
    logic        ok;
  } variant_t;

  function automatic variant_t mk(logic [31:0] poly, logic [31:0] init,
                                  logic [31:0] xorout, logic refl);
    variant_t v;
    v.poly   = poly;
    v.init   = init;
    v.xorout = xorout;
    v.refl   = refl;
    v.ok     = 1'b1;
    return v;
  endfunction

  // Catalogue lookup; reflected variants keep poly and init reflected
  function automatic variant_t preset_lookup(logic [1:0] width, logic [4:0] idx);
    variant_t v;
    v = '0;
    case (width)
      WIDTH_CRC8: begin
        case (idx)
          5'd0:  v = mk(32'h07, 32'h00, 32'h00, 1'b0);
          5'd1:  v = mk(32'h9B, 32'hFF, 32'h00, 1'b0);
          5'd2:  v = mk(32'h9C, 32'h00, 32'h00, 1'b1);
          5'd3:  v = mk(32'hD5, 32'h00, 32'h00, 1'b0);
          5'd4:  v = mk(32'hB8, 32'hFF, 32'h00, 1'b1);
          5'd5:  v = mk(32'h1D, 32'hFD, 32'h00, 1'b0);
          5'd6:  v = mk(32'h07, 32'h00, 32'h55, 1'b0);
          5'd7:  v = mk(32'h8C, 32'h00, 32'h00, 1'b1);
          5'd8:  v = mk(32'hE0, 32'hFF, 32'h00, 1'b1);
          5'd9:  v = mk(32'hD9, 32'h00, 32'h00, 1'b1);
          5'd10: v = mk(32'h2F, 32'hFF, 32'hFF, 1'b0);
          5'd11: v = mk(32'hE5, 32'h00, 32'h00, 1'b1);
          5'd12: v = mk(32'h9B, 32'h00, 32'h00, 1'b0);
          default: v = '0;
        endcase
      end
      WIDTH_CRC16: begin
        case (idx)
          5'd1:  v = mk(32'h1021, 32'hFFFF, 32'h0000, 1'b0);
          5'd2:  v = mk(32'hA001, 32'h0000, 32'h0000, 1'b1);
          5'd3:  v = mk(32'h1021, 32'h1D0F, 32'h0000, 1'b0);
          5'd4:  v = mk(32'h8005, 32'h0000, 32'h0000, 1'b0);
          5'd5:  v = mk(32'hC867, 32'hFFFF, 32'h0000, 1'b0);
          5'd6:  v = mk(32'h8005, 32'h800D, 32'h0000, 1'b0);
          5'd7:  v = mk(32'h0589, 32'h0000, 32'h0001, 1'b0);
          5'd8:  v = mk(32'h0589, 32'h0000, 32'h0000, 1'b0);
          5'd9:  v = mk(32'hA6BC, 32'h0000, 32'hFFFF, 1'b1);
          5'd10: v = mk(32'h3D65, 32'h0000, 32'hFFFF, 1'b0);
          5'd11: v = mk(32'h1021, 32'hFFFF, 32'hFFFF, 1'b0);
          5'd12: v = mk(32'hA001, 32'h0000, 32'hFFFF, 1'b1);
          5'd13: v = mk(32'h8408, 32'hFFFF, 32'h0000, 1'b1);
          5'd14: v = mk(32'h8408, 32'h554D, 32'h0000, 1'b1);
          5'd15: v = mk(32'h8BB7, 32'h0000, 32'h0000, 1'b0);
          5'd16: v = mk(32'hA097, 32'h0000, 32'h0000, 1'b0);
          5'd17: v = mk(32'h8408, 32'h3791, 32'h0000, 1'b1);
          5'd18: v = mk(32'hA001, 32'hFFFF, 32'hFFFF, 1'b1);
          5'd19: v = mk(32'h8408, 32'h6363, 32'h0000, 1'b1);
          5'd20: v = mk(32'h8408, 32'h0000, 32'h0000, 1'b1);
          5'd21: v = mk(32'hA001, 32'hFFFF, 32'h0000, 1'b1);
          5'd22: v = mk(32'h8408, 32'hFFFF, 32'hFFFF, 1'b1);
          5'd23: v = mk(32'h1021, 32'h0000, 32'h0000, 1'b0);
          5'd24: v = mk(32'hA01C, 32'h0000, 32'h0000, 1'b0);
          default: v = '0;
        endcase
      end
      WIDTH_CRC32: begin
        case (idx)
          5'd0: v = mk(32'hEDB88320, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
          5'd1: v = mk(32'h04C11DB7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
          5'd2: v = mk(32'h82F63B78, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
          5'd3: v = mk(32'hD419CC15, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
          5'd4: v = mk(32'h04C11DB7, 32'hFFFFFFFF, 32'h00000000, 1'b0);
          5'd5: v = mk(32'h04C11DB7, 32'h00000000, 32'hFFFFFFFF, 1'b0);
          5'd6: v = mk(32'h814141AB, 32'h00000000, 32'h00000000, 1'b0);
          5'd7: v = mk(32'hEDB88320, 32'hFFFFFFFF, 32'h00000000, 1'b1);
          5'd8: v = mk(32'h000000AF, 32'h00000000, 32'h00000000, 1'b0);
          default: v = '0;
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  // Eight bit steps of an 8-bit CRC
  function automatic logic [7:0] fold8(variant_t v, logic [7:0] r, logic [7:0] b);
    logic [7:0] c;
    c = r ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v.refl) begin
        c = c[0] ? ((c >> 1) ^ v.poly[7:0]) : (c >> 1);
      end else begin
        c = c[7] ? ((c << 1) ^ v.poly[7:0]) : (c << 1);
      end
    end
    return c;
  endfunction

  // Eight bit steps of a 16-bit CRC
  function automatic logic [15:0] fold16(variant_t v, logic [15:0] r, logic [7:0] b);
    logic [15:0] c;
    c = v.refl ? (r ^ {8'h00, b}) : (r ^ {b, 8'h00});
    for (int i = 0; i < 8; i++) begin
      if (v.refl) begin
        c = c[0] ? ((c >> 1) ^ v.poly[15:0]) : (c >> 1);
      end else begin
        c = c[15] ? ((c << 1) ^ v.poly[15:0]) : (c << 1);
      end
    end
    return c;
  endfunction

  // Eight bit steps of a 32-bit CRC
  function automatic logic [31:0] fold32(variant_t v, logic [31:0] r, logic [7:0] b);
    logic [31:0] c;
    c = v.refl ? (r ^ {24'h000000, b}) : (r ^ {b, 24'h000000});
    for (int i = 0; i < 8; i++) begin
      if (v.refl) begin
        c = c[0] ? ((c >> 1) ^ v.poly) : (c >> 1);
      end else begin
        c = c[31] ? ((c << 1) ^ v.poly) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mwcrc_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcrc interfaces
// Valid/ready channels for message bytes, CRC results and register writes.
// ----------------------------------------------------------------------------

// Message byte channel
interface mwcrc_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;
  logic       has_data;

  modport source (output valid, data_byte, first, last, has_data, input ready);
  modport sink   (input valid, data_byte, first, last, has_data, output ready);
endinterface

// CRC result channel
interface mwcrc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;
  logic        preset_valid;

  modport source (output valid, crc_value, preset_valid, input ready);
  modport sink   (input valid, crc_value, preset_valid, output ready);
endinterface

// Register write channel
interface mwcrc_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [4:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/multi_width_crc_preset_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_width_crc_preset_engine_top
// Byte-serial CRC-8/16/32 engine with a fixed preset catalogue.
// ----------------------------------------------------------------------------
// Result: registered on the transfer of a last byte.
// Throughput: one byte per cycle while the input is not stalled; the eight bit
// steps are one xor network between the CRC register and itself.
// Input stalls only while a held result is not taken.
// Reset: CRC register, width and preset cleared, result channel empty.
// Register writes are always accepted.

module multi_width_crc_preset_engine_top (
  input  logic         clk,
  input  logic         rst,
  mwcrc_msg_if.sink    msg,
  mwcrc_res_if.source  res,
  mwcrc_cfg_if.sink    cfg
);

  logic [1:0]            crc_width;
  logic [4:0]            preset;
  logic [31:0]           crc_register;
  logic                  res_valid;
  logic [31:0]           res_crc;
  logic                  res_ok;

  mwcrc_pkg::variant_t   var_sel;
  logic [31:0]           base;
  logic [31:0]           folded;
  logic [31:0]           crc_register_next;
  logic [31:0]           width_mask;
  logic [31:0]           res_crc_next;
  logic                  msg_xfer;

  // Register write port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_width <= mwcrc_pkg::WIDTH_CRC8;
      preset    <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        mwcrc_pkg::CFG_CRC_WIDTH: crc_width <= cfg.data[1:0];
        mwcrc_pkg::CFG_PRESET:    preset    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Preset decode
  assign var_sel = mwcrc_pkg::preset_lookup(crc_width, preset);

  // Byte fold for the selected width
  always_comb begin
    base = msg.first ? var_sel.init : crc_register;
    case (crc_width)
      mwcrc_pkg::WIDTH_CRC8: begin
        folded     = {24'h000000, mwcrc_pkg::fold8(var_sel, base[7:0], msg.data_byte)};
        width_mask = 32'h000000FF;
      end
      mwcrc_pkg::WIDTH_CRC16: begin
        folded     = {16'h0000, mwcrc_pkg::fold16(var_sel, base[15:0], msg.data_byte)};
        width_mask = 32'h0000FFFF;
      end
      default: begin
        folded     = mwcrc_pkg::fold32(var_sel, base, msg.data_byte);
        width_mask = 32'hFFFFFFFF;
      end
    endcase
    if (var_sel.ok) begin
      crc_register_next = msg.has_data ? folded : base;
      res_crc_next      = (crc_register_next ^ var_sel.xorout) & width_mask;
    end else begin
      crc_register_next = crc_register;
      res_crc_next      = '0;
    end
  end

  // Input held only while a pending result is not taken
  assign msg.ready = !res_valid || res.ready;
  assign msg_xfer  = msg.valid && msg.ready;

  // CRC state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= '0;
    end else if (msg_xfer) begin
      crc_register <= crc_register_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (msg_xfer && msg.last) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_xfer && msg.last) begin
      res_crc <= res_crc_next;
      res_ok  <= var_sel.ok;
    end
  end

  assign res.valid        = res_valid;
  assign res.crc_value    = res_crc;
  assign res.preset_valid = res_ok;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-width CRC preset engine. The bench covers
// directed cases (reset state, byte extremes, empty messages, unknown presets,
// width switches), a sweep over every width/preset pair, and random messages
// under bursty input and a stalling result sink. An in-bench CRC predictor
// builds the expected results, and each result transfer is checked in order.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int ITEM_TARGET    = 800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 3;

  // One catalogue entry as the predictor sees it
  typedef struct packed {
    logic [31:0] poly;
    logic [31:0] init;
    logic [31:0] xorout;
    logic        refl;
    logic        ok;
  } crc_preset_t;

  typedef struct packed {
    logic [31:0] crc;
    logic        known;
  } crc_result_t;

  logic clk;
  logic rst;

  mwcrc_msg_if msg_ch ();
  mwcrc_res_if res_ch ();
  mwcrc_cfg_if cfg_ch ();

  multi_width_crc_preset_engine_top dut (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // Predictor state: register copies and the running CRC
  logic [1:0]  cur_width;
  logic [4:0]  cur_preset;
  logic [31:0] crc_state;
  crc_result_t expected_crcs[$];
  crc_result_t want;

  int errors;
  int items_sent;
  int results_seen;
  int cfg_writes;
  int burst_left;
  int idle_cycles;
  logic [9:0] stall_phase;

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Preset catalogue; reflected entries hold reflected poly and init
  function automatic crc_preset_t crc_catalogue(logic [1:0] w, logic [4:0] p);
    crc_preset_t e;
    e = '0;
    case (w)
      mwcrc_pkg::WIDTH_CRC8: begin
        case (p)
          5'd0:  e = '{32'h07, 32'h00, 32'h00, 1'b0, 1'b1};
          5'd1:  e = '{32'h9B, 32'hFF, 32'h00, 1'b0, 1'b1};
          5'd2:  e = '{32'h9C, 32'h00, 32'h00, 1'b1, 1'b1};
          5'd3:  e = '{32'hD5, 32'h00, 32'h00, 1'b0, 1'b1};
          5'd4:  e = '{32'hB8, 32'hFF, 32'h00, 1'b1, 1'b1};
          5'd5:  e = '{32'h1D, 32'hFD, 32'h00, 1'b0, 1'b1};
          5'd6:  e = '{32'h07, 32'h00, 32'h55, 1'b0, 1'b1};
          5'd7:  e = '{32'h8C, 32'h00, 32'h00, 1'b1, 1'b1};
          5'd8:  e = '{32'hE0, 32'hFF, 32'h00, 1'b1, 1'b1};
          5'd9:  e = '{32'hD9, 32'h00, 32'h00, 1'b1, 1'b1};
          5'd10: e = '{32'h2F, 32'hFF, 32'hFF, 1'b0, 1'b1};
          5'd11: e = '{32'hE5, 32'h00, 32'h00, 1'b1, 1'b1};
          5'd12: e = '{32'h9B, 32'h00, 32'h00, 1'b0, 1'b1};
          default: e = '0;
        endcase
      end
      mwcrc_pkg::WIDTH_CRC16: begin
        case (p)
          5'd1:  e = '{32'h1021, 32'hFFFF, 32'h0000, 1'b0, 1'b1};
          5'd2:  e = '{32'hA001, 32'h0000, 32'h0000, 1'b1, 1'b1};
          5'd3:  e = '{32'h1021, 32'h1D0F, 32'h0000, 1'b0, 1'b1};
          5'd4:  e = '{32'h8005, 32'h0000, 32'h0000, 1'b0, 1'b1};
          5'd5:  e = '{32'hC867, 32'hFFFF, 32'h0000, 1'b0, 1'b1};
          5'd6:  e = '{32'h8005, 32'h800D, 32'h0000, 1'b0, 1'b1};
          5'd7:  e = '{32'h0589, 32'h0000, 32'h0001, 1'b0, 1'b1};
          5'd8:  e = '{32'h0589, 32'h0000, 32'h0000, 1'b0, 1'b1};
          5'd9:  e = '{32'hA6BC, 32'h0000, 32'hFFFF, 1'b1, 1'b1};
          5'd10: e = '{32'h3D65, 32'h0000, 32'hFFFF, 1'b0, 1'b1};
          5'd11: e = '{32'h1021, 32'hFFFF, 32'hFFFF, 1'b0, 1'b1};
          5'd12: e = '{32'hA001, 32'h0000, 32'hFFFF, 1'b1, 1'b1};
          5'd13: e = '{32'h8408, 32'hFFFF, 32'h0000, 1'b1, 1'b1};
          5'd14: e = '{32'h8408, 32'h554D, 32'h0000, 1'b1, 1'b1};
          5'd15: e = '{32'h8BB7, 32'h0000, 32'h0000, 1'b0, 1'b1};
          5'd16: e = '{32'hA097, 32'h0000, 32'h0000, 1'b0, 1'b1};
          5'd17: e = '{32'h8408, 32'h3791, 32'h0000, 1'b1, 1'b1};
          5'd18: e = '{32'hA001, 32'hFFFF, 32'hFFFF, 1'b1, 1'b1};
          5'd19: e = '{32'h8408, 32'h6363, 32'h0000, 1'b1, 1'b1};
          5'd20: e = '{32'h8408, 32'h0000, 32'h0000, 1'b1, 1'b1};
          5'd21: e = '{32'hA001, 32'hFFFF, 32'h0000, 1'b1, 1'b1};
          5'd22: e = '{32'h8408, 32'hFFFF, 32'hFFFF, 1'b1, 1'b1};
          5'd23: e = '{32'h1021, 32'h0000, 32'h0000, 1'b0, 1'b1};
          5'd24: e = '{32'hA01C, 32'h0000, 32'h0000, 1'b0, 1'b1};
          default: e = '0;
        endcase
      end
      mwcrc_pkg::WIDTH_CRC32: begin
        case (p)
          5'd0: e = '{32'hEDB88320, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1};
          5'd1: e = '{32'h04C11DB7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b1};
          5'd2: e = '{32'h82F63B78, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1};
          5'd3: e = '{32'hD419CC15, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1};
          5'd4: e = '{32'h04C11DB7, 32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b1};
          5'd5: e = '{32'h04C11DB7, 32'h00000000, 32'hFFFFFFFF, 1'b0, 1'b1};
          5'd6: e = '{32'h814141AB, 32'h00000000, 32'h00000000, 1'b0, 1'b1};
          5'd7: e = '{32'hEDB88320, 32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b1};
          5'd8: e = '{32'h000000AF, 32'h00000000, 32'h00000000, 1'b0, 1'b1};
          default: e = '0;
        endcase
      end
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic int crc_bits(logic [1:0] w);
    return (w == mwcrc_pkg::WIDTH_CRC8) ? 8 :
           (w == mwcrc_pkg::WIDTH_CRC16) ? 16 : 32;
  endfunction

  function automatic logic [31:0] crc_mask(logic [1:0] w);
    return (w == mwcrc_pkg::WIDTH_CRC8) ? 32'hFF :
           (w == mwcrc_pkg::WIDTH_CRC16) ? 32'hFFFF : 32'hFFFF_FFFF;
  endfunction

  // Eight shift/xor steps on the register, truncated to the active width
  function automatic logic [31:0] crc_fold_byte(crc_preset_t e, logic [1:0] w,
                                                logic [31:0] r, logic [7:0] b);
    int nb;
    logic [31:0] m;
    logic [31:0] top;
    nb  = crc_bits(w);
    m   = crc_mask(w);
    top = 32'h1 << (nb - 1);
    r   = r & m;
    if (e.refl) begin
      r = r ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
        r = r[0] ? ((r >> 1) ^ e.poly) : (r >> 1);
      end
    end else begin
      r = r ^ (({24'h0, b} << (nb - 8)) & m);
      for (int i = 0; i < 8; i++) begin
        r = ((r & top) != 0) ? (((r << 1) ^ e.poly) & m) : ((r << 1) & m);
      end
    end
    return r & m;
  endfunction

  // Update the running CRC for one accepted item; queue a result on last
  function automatic void crc_predict_item(logic [7:0] b, logic f, logic l, logic h);
    crc_preset_t e;
    crc_result_t r;
    e = crc_catalogue(cur_width, cur_preset);
    if (e.ok) begin
      if (f) crc_state = e.init;
      if (h) crc_state = crc_fold_byte(e, cur_width, crc_state, b);
    end
    if (l) begin
      if (e.ok) begin
        r.crc   = (crc_state ^ e.xorout) & crc_mask(cur_width);
        r.known = 1'b1;
      end else begin
        r.crc   = 32'h0;
        r.known = 1'b0;
      end
      expected_crcs.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("MISMATCH @%0t: %s expected %h got %h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  // Send one item: bursts of random length separated by random gaps
  task automatic send_item(input logic [7:0] b, input logic f, input logic l,
                           input logic h);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        msg_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    msg_ch.valid     <= 1'b1;
    msg_ch.data_byte <= b;
    msg_ch.first     <= f;
    msg_ch.last      <= l;
    msg_ch.has_data  <= h;
    do @(posedge clk); while (!msg_ch.ready);
    crc_predict_item(b, f, l, h);
    items_sent++;
  endtask

  // Stop sending and wait until the engine has nothing left in flight
  task automatic settle();
    msg_ch.valid <= 1'b0;
    while (expected_crcs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == mwcrc_pkg::CFG_CRC_WIDTH) cur_width = val[1:0];
    else cur_preset = val;
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_preset(input logic [1:0] w, input logic [4:0] p);
    settle();
    write_reg(mwcrc_pkg::CFG_CRC_WIDTH, {3'b000, w});
    write_reg(mwcrc_pkg::CFG_PRESET, p);
  endtask

  // Well-formed message of n bytes with random content
  task automatic send_message(input int n);
    for (int k = 0; k < n; k++) begin
      send_item(8'($urandom), k == 0, k == n - 1, 1'b1);
    end
  endtask

  // Bytes right after reset continue from a cleared register, no first seen
  task automatic test_reset_state();
    send_item(8'h80, 1'b0, 1'b0, 1'b1);
    send_item(8'h01, 1'b0, 1'b1, 1'b1);
  endtask

  // Byte extremes on one preset of each width, plus a one-item message
  task automatic test_byte_extremes();
    set_preset(mwcrc_pkg::WIDTH_CRC32, 5'd0);
    send_item(8'h00, 1'b1, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1, 1'b1);
    set_preset(mwcrc_pkg::WIDTH_CRC16, 5'd1);
    send_item(8'h00, 1'b1, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1, 1'b1);
    set_preset(mwcrc_pkg::WIDTH_CRC8, 5'd10);
    send_item(8'hFF, 1'b1, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1, 1'b1);
  endtask

  // Empty messages give init ^ xorout; a data-less last just flushes
  task automatic test_empty_message();
    set_preset(mwcrc_pkg::WIDTH_CRC32, 5'd0);
    send_item(8'hFF, 1'b1, 1'b1, 1'b0);
    set_preset(mwcrc_pkg::WIDTH_CRC16, 5'd7);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'h31, 1'b1, 1'b0, 1'b1);
    send_item(8'hAA, 1'b0, 1'b1, 1'b0);
  endtask

  // Unknown pairs return 0 and a cleared valid flag
  task automatic test_unknown_preset();
    set_preset(mwcrc_pkg::WIDTH_CRC16, 5'd0);
    send_item(8'h5A, 1'b1, 1'b1, 1'b1);
    set_preset(2'd3, 5'd31);
    send_item(8'hA5, 1'b1, 1'b1, 1'b1);
    set_preset(mwcrc_pkg::WIDTH_CRC8, 5'd13);
    send_item(8'h3C, 1'b1, 1'b1, 1'b1);
  endtask

  // Width change between bytes of a message truncates the running register
  task automatic test_width_switch();
    set_preset(mwcrc_pkg::WIDTH_CRC32, 5'd1);
    send_item(8'hA5, 1'b1, 1'b0, 1'b1);
    set_preset(mwcrc_pkg::WIDTH_CRC8, 5'd0);
    send_item(8'h3C, 1'b0, 1'b1, 1'b1);
    set_preset(mwcrc_pkg::WIDTH_CRC16, 5'd24);
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
  endtask

  // Every width/preset pair, including the unused ones
  task automatic test_preset_sweep();
    for (int w = 0; w < 4; w++) begin
      for (int p = 0; p < 32; p++) begin
        set_preset(2'(w), 5'(p));
        send_message($urandom_range(1, 3));
      end
    end
  endtask

  // Random settings and messages: mostly well-formed, some broken or noise
  task automatic test_random_messages();
    int kind;
    int n;
    int pos;
    logic [1:0] w;
    logic [4:0] p;
    logic [2:0] hi;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        settle();
        if ($urandom_range(0, 9) < 8) begin
          w = 2'($urandom_range(0, 2));
          p = (w == mwcrc_pkg::WIDTH_CRC8)  ? 5'($urandom_range(0, 12)) :
              (w == mwcrc_pkg::WIDTH_CRC16) ? 5'($urandom_range(1, 24)) :
                                              5'($urandom_range(0, 8));
        end else begin
          w = 2'($urandom_range(0, 3));
          p = 5'($urandom_range(0, 31));
        end
        // unused upper data bits on the width write
        hi = 3'($urandom_range(0, 7));
        kind = $urandom_range(0, 3);
        if (kind != 1) write_reg(mwcrc_pkg::CFG_CRC_WIDTH, {hi, w});
        if (kind != 2) write_reg(mwcrc_pkg::CFG_PRESET, p);
      end
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        send_item(8'($urandom), 1'b1, 1'b1, 1'b0);
      end else if (kind == 1) begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end else if (kind == 2) begin
        // first missing or restarted partway through
        n = $urandom_range(2, 8);
        pos = $urandom_range(1, n);
        for (int k = 0; k < n; k++) begin
          send_item(8'($urandom), k == pos, k == n - 1, 1'($urandom_range(0, 4) != 0));
        end
      end else if (kind == 3) begin
        send_message($urandom_range(20, 40));
      end else begin
        send_message($urandom_range(1, 10));
      end
    end
  endtask

  // Result sink: stall pattern follows the top two bits of a free-running phase counter
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[9:8])
      2'd0: res_ch.ready <= 1'b1;
      2'd1: res_ch.ready <= ($urandom_range(0, 1) == 0);
      2'd2: res_ch.ready <= (stall_phase[2:0] == 3'd7);
      default: res_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_crcs.size() == 0) begin
        report_mismatch("result with none expected", 32'h0, res_ch.crc_value);
      end else begin
        want = expected_crcs.pop_front();
        if (res_ch.crc_value !== want.crc) begin
          report_mismatch("crc_value", want.crc, res_ch.crc_value);
        end
        if (res_ch.preset_valid !== want.known) begin
          report_mismatch("preset_valid", {31'h0, want.known}, {31'h0, res_ch.preset_valid});
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_crcs.size());
      $display("multi_width_crc_preset_engine_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    msg_ch.valid     = 1'b0;
    msg_ch.data_byte = 8'h00;
    msg_ch.first     = 1'b0;
    msg_ch.last      = 1'b0;
    msg_ch.has_data  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = mwcrc_pkg::CFG_CRC_WIDTH;
    cfg_ch.data      = 5'd0;
    res_ch.ready     = 1'b0;
    stall_phase      = '0;
    idle_cycles      = 0;
    cur_width        = mwcrc_pkg::WIDTH_CRC8;
    cur_preset       = 5'd0;
    crc_state        = 32'h0;
    errors           = 0;
    items_sent       = 0;
    results_seen     = 0;
    cfg_writes       = 0;
    burst_left       = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_byte_extremes();
    test_empty_message();
    test_unknown_preset();
    test_width_switch();
    test_preset_sweep();
    test_random_messages();
    settle();

    $display("covered %0d items, %0d results, %0d register writes", items_sent,
             results_seen, cfg_writes);
    $display("all 128 width/preset pairs swept; %0d mismatches", errors);
    if (errors == 0) begin
      $display("multi_width_crc_preset_engine_top regression: pass");
    end else begin
      $display("multi_width_crc_preset_engine_top regression: fail");
    end
    $finish;
  end

endmodule
